### design/cav_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the CORDIC vectoring-mode atan2 core.
// Holds the arctangent step table and the angle and output formats; no dependencies.
package cav_pkg;

  localparam int ANG_FRAC = 16;
  localparam int OUT_FRAC = 8;
  localparam int ANG_W = 26;
  localparam int OUT_W = 17;
  localparam int TABLE_LEN = 24;
  localparam int RND_W = ANG_W + 1 - (ANG_FRAC - OUT_FRAC);

  typedef logic signed [ANG_W-1:0] ang_t;
  typedef logic signed [OUT_W-1:0] angle_t;

  localparam ang_t QUARTER_TURN = 26'sd5898240;
  localparam logic signed [ANG_W:0] ROUND_HALF = 27'sd128;
  localparam logic signed [RND_W-1:0] OUT_LIMIT = 19'sd46080;

  // atan(2^-i) in degrees with 16 fractional bits, rounded to nearest.
  localparam ang_t ATAN_TAB [TABLE_LEN] = '{
    26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945,
    26'sd234379,  26'sd117304,  26'sd58666,  26'sd29335,
    26'sd14668,   26'sd7334,    26'sd3667,   26'sd1833,
    26'sd917,     26'sd458,     26'sd229,    26'sd115,
    26'sd57,      26'sd29,      26'sd14,     26'sd7,
    26'sd4,       26'sd2,       26'sd1,      26'sd0
  };

endpackage

### design/cav_if.sv
`timescale 1ns / 1ps
// Valid/ready stream interfaces for the CORDIC atan2 core: samples in, phases out.
// Depends on cav_pkg for the output angle type.
interface cav_in_if #(
  parameter int DATA_WIDTH = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] real_part;
  logic signed [DATA_WIDTH-1:0] imag_part;

  modport source(output valid, real_part, imag_part, input ready);
  modport sink(input valid, real_part, imag_part, output ready);
endinterface

interface cav_out_if;
  logic            valid;
  logic            ready;
  cav_pkg::angle_t angle_deg;

  modport source(output valid, angle_deg, input ready);
  modport sink(input valid, angle_deg, output ready);
endinterface

### design/cordic_atan2_vectoring_core.sv
`timescale 1ns / 1ps
// Pipelined CORDIC vectoring-mode atan2: sample phase in degrees, 8 fractional bits.
// Depends on cav_pkg and the stream interfaces in cav_if.sv.
//
// The core takes one complex sample per clock and returns its phase through one
// register stage for the quarter-turn pre-rotation, one per shift-and-add
// micro-rotation, and one for rounding and saturation. Every stage has its own
// valid bit and advances when the stage after it is empty or moving, so a
// stalled output only holds back the stages that are full, and a new sample is
// taken whenever any stage has room.
module cordic_atan2_vectoring_core #(
  parameter int ITERATIONS = 11,
  parameter int DATA_WIDTH = 16
) (
  input logic         clk,
  input logic         rst,
  cav_in_if.sink      sample,
  cav_out_if.source   phase
);

  localparam int N = (ITERATIONS < cav_pkg::TABLE_LEN) ? ITERATIONS : cav_pkg::TABLE_LEN;
  localparam int W = DATA_WIDTH + 3;
  localparam int LAST = N + 1;
  localparam int SH = cav_pkg::ANG_FRAC - cav_pkg::OUT_FRAC;

  logic signed [W-1:0] x [0:N];
  logic signed [W-1:0] y [0:N];
  cav_pkg::ang_t       ph [0:N];
  logic                vld [0:LAST];
  logic                adv [0:LAST];
  cav_pkg::angle_t     angle;

  logic signed [W-1:0]               re_ext;
  logic signed [W-1:0]               im_ext;
  logic signed [cav_pkg::ANG_W:0]    rnd;
  logic signed [cav_pkg::RND_W-1:0]  rsh;
  logic signed [cav_pkg::RND_W-1:0]  sat;

  assign adv[LAST] = !vld[LAST] || phase.ready;

  genvar k;
  generate
    for (k = 0; k < LAST; k++) begin : g_adv
      assign adv[k] = !vld[k] || adv[k+1];
    end
  endgenerate

  assign sample.ready = adv[0];

  assign re_ext = W'(sample.real_part);
  assign im_ext = W'(sample.imag_part);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (adv[0]) begin
      vld[0] <= sample.valid;
    end
    if (adv[0] && sample.valid) begin
      if (sample.imag_part > 0) begin
        x[0]  <= im_ext;
        y[0]  <= -re_ext;
        ph[0] <= -cav_pkg::QUARTER_TURN;
      end else begin
        x[0]  <= -im_ext;
        y[0]  <= re_ext;
        ph[0] <= cav_pkg::QUARTER_TURN;
      end
    end
  end

  generate
    for (k = 0; k < N; k++) begin : g_stage
      logic signed [W-1:0] xs;
      logic signed [W-1:0] ys;

      assign xs = x[k] >>> k;
      assign ys = y[k] >>> k;

      always_ff @(posedge clk) begin
        if (rst) begin
          vld[k+1] <= 1'b0;
        end else if (adv[k+1]) begin
          vld[k+1] <= vld[k];
        end
        if (adv[k+1] && vld[k]) begin
          if (!y[k][W-1]) begin
            x[k+1]  <= x[k] + ys;
            y[k+1]  <= y[k] - xs;
            ph[k+1] <= ph[k] - cav_pkg::ATAN_TAB[k];
          end else begin
            x[k+1]  <= x[k] - ys;
            y[k+1]  <= y[k] + xs;
            ph[k+1] <= ph[k] + cav_pkg::ATAN_TAB[k];
          end
        end
      end
    end
  endgenerate

  // Negate, round half up to the output resolution, then clamp to +-180 degrees.
  always_comb begin
    rnd = -{ph[N][cav_pkg::ANG_W-1], ph[N]} + cav_pkg::ROUND_HALF;
    rsh = cav_pkg::RND_W'(rnd >>> SH);
    if (rsh > cav_pkg::OUT_LIMIT) begin
      sat = cav_pkg::OUT_LIMIT;
    end else if (rsh < -cav_pkg::OUT_LIMIT) begin
      sat = -cav_pkg::OUT_LIMIT;
    end else begin
      sat = rsh;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[LAST] <= 1'b0;
    end else if (adv[LAST]) begin
      vld[LAST] <= vld[N];
    end
    if (adv[LAST] && vld[N]) begin
      angle <= sat[cav_pkg::OUT_W-1:0];
    end
  end

  assign phase.valid     = vld[LAST];
  assign phase.angle_deg = angle;

endmodule

### design/cav_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the CORDIC atan2 core and the bind that attaches them.
// Depends on cav_pkg and on the port list of cordic_atan2_vectoring_core.
module cav_checker #(
  parameter int ITERATIONS = 11,
  parameter int DATA_WIDTH = 16
) (
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input cav_pkg::angle_t angle_deg
);

  localparam int N = (ITERATIONS < cav_pkg::TABLE_LEN) ? ITERATIONS : cav_pkg::TABLE_LEN;
  localparam int DEPTH = N + 2;
  localparam int CW = $clog2(DEPTH + 1) + 1;
  localparam int DW = DATA_WIDTH;

  logic [CW-1:0] inflight;
  logic          in_take;
  logic          out_take;

  assign in_take  = in_valid && in_ready;
  assign out_take = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight + CW'(in_take) - CW'(out_take);
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    inflight <= CW'(DEPTH))
    else $error("more transactions in flight than pipeline stages (width %0d)", DW);

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> inflight != '0)
    else $error("result offered with no sample in flight");

  a_room_accepts: assert property (@(posedge clk) disable iff (rst)
    inflight < CW'(DEPTH) |-> in_ready)
    else $error("input stalled although a pipeline stage is free");

  a_out_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (angle_deg <= 17'sd46080) && (angle_deg >= -17'sd46080))
    else $error("phase outside +-180 degrees");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(angle_deg))
    else $error("stalled result changed or dropped");

endmodule

bind cordic_atan2_vectoring_core cav_checker #(
  .ITERATIONS(ITERATIONS),
  .DATA_WIDTH(DATA_WIDTH)
) u_cav_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(sample.valid),
  .in_ready(sample.ready),
  .out_valid(phase.valid),
  .out_ready(phase.ready),
  .angle_deg(phase.angle_deg)
);
